/* rtl/internet_checksum_pseudo_header_unit_macros.svh */
// assertion macros for the internet checksum pseudo-header unit
// no dependencies; included by the top level
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_MACROS_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ICPH_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("icph assertion failed");

// next-cycle implication
`define ICPH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("icph assertion failed");

`else

`define ICPH_ASSERT_SAME(label, clk, rstn, ante, cons)
`define ICPH_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/icph_pkg.sv */
// shared constants for the internet checksum pseudo-header unit
// no dependencies
package icph_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned KIND_W  = 2;

    // header kind codes; the unused code is treated as plain
    localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UDP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TCP   = 2'd2;

    localparam logic [WORD_W-1:0] PROTO_UDP       = 16'd17;
    localparam logic [WORD_W-1:0] PROTO_TCP       = 16'd6;
    localparam logic [WORD_W-1:0] PSEUDO_LEN_BIAS = 16'd8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;

endpackage

/* rtl/internet_checksum_pseudo_header_unit.sv */
// internet checksum unit: input register, one sum/fold stage, result register
// the last byte passes through the input register and then the result register before its checksum beat is offered
// throughput: one byte per cycle; a stall only while a finished checksum is not taken
// the four-term add and double carry fold sit between the input and result registers
// reset: synchronous active-low aresetn empties both registers and ends any open message
// depends on icph_pkg and internet_checksum_pseudo_header_unit_macros.svh
`include "internet_checksum_pseudo_header_unit_macros.svh"

module internet_checksum_pseudo_header_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  icph_pkg::byte_t       s_data_byte,
    input  icph_pkg::kind_t       s_header_kind,
    input  logic                  s_last_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output icph_pkg::word_t       m_checksum_value
);
    import icph_pkg::*;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;
    kind_t in_kind_reg;
    logic  in_last_reg;

    // message state
    word_t running_sum_reg,  running_sum_next;
    byte_t held_high_reg,    held_high_next;
    logic  byte_pending_reg, byte_pending_next;
    word_t bytes_seen_reg,   bytes_seen_next;
    kind_t active_kind_reg,  active_kind_next;
    logic  in_message_reg,   in_message_next;

    // result register
    logic  m_valid_reg;
    word_t m_value_reg;

    logic  out_free;
    logic  stage_go;
    logic  pending;
    kind_t kind;
    logic  pseudo;
    word_t base_sum;
    word_t word_term;
    word_t proto_term;
    word_t len_term;
    logic [WORD_W+1:0] raw_sum;
    logic [WORD_W:0]   fold1;
    word_t             folded;

    assign out_free = !m_valid_reg || m_ready;
    assign stage_go = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || stage_go;

    always_comb begin
        // a new message starts from cleared state
        pending  = in_message_reg && byte_pending_reg;
        base_sum = in_message_reg ? running_sum_reg : '0;
        kind     = in_message_reg ? active_kind_reg : in_kind_reg;
        pseudo   = (kind == KIND_UDP) || (kind == KIND_TCP);

        bytes_seen_next = (in_message_reg ? bytes_seen_reg : '0) + 16'd1;

        if (pending) begin
            word_term = {held_high_reg, in_byte_reg};
        end else if (in_last_reg) begin
            // unpaired final byte goes in as a high byte
            word_term = {in_byte_reg, {BYTE_W{1'b0}}};
        end else begin
            word_term = '0;
        end

        proto_term = '0;
        len_term   = '0;
        if (in_last_reg && pseudo) begin
            proto_term = (kind == KIND_UDP) ? PROTO_UDP : PROTO_TCP;
            len_term   = bytes_seen_next - PSEUDO_LEN_BIAS;
        end

        // end-around carry over all terms at once: fold twice
        raw_sum = {2'b00, base_sum} + {2'b00, word_term}
                + {2'b00, proto_term} + {2'b00, len_term};
        fold1   = {1'b0, raw_sum[WORD_W-1:0]} + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W+1:WORD_W]};
        folded  = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};

        running_sum_next  = folded;
        held_high_next    = pending ? held_high_reg : in_byte_reg;
        byte_pending_next = !in_last_reg && !pending;
        active_kind_next  = kind;
        in_message_next   = !in_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_kind_reg <= s_header_kind;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg  <= '0;
            held_high_reg    <= '0;
            byte_pending_reg <= 1'b0;
            bytes_seen_reg   <= '0;
            active_kind_reg  <= KIND_PLAIN;
            in_message_reg   <= 1'b0;
        end else if (stage_go) begin
            running_sum_reg  <= running_sum_next;
            held_high_reg    <= held_high_next;
            byte_pending_reg <= byte_pending_next;
            bytes_seen_reg   <= bytes_seen_next;
            active_kind_reg  <= active_kind_next;
            in_message_reg   <= in_message_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stage_go && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_go && in_last_reg) begin
            m_value_reg <= ~folded;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_checksum_value = m_value_reg;

    `ICPH_ASSERT_NEXT(a_last_gives_beat, aclk, aresetn, stage_go && in_last_reg, m_valid_reg && !in_message_reg)
    `ICPH_ASSERT_NEXT(a_mid_keeps_message, aclk, aresetn, stage_go && !in_last_reg, in_message_reg)
    `ICPH_ASSERT_SAME(a_idle_no_pending, aclk, aresetn, !in_message_reg, !byte_pending_reg)
    `ICPH_ASSERT_SAME(a_stall_only_on_full, aclk, aresetn, in_valid_reg && !stage_go, m_valid_reg && !m_ready)

endmodule
